// File: src/dfusp_pkg.sv
package dfusp_pkg;

  typedef enum logic [1:0] {
    SFX_VALID   = 2'd0,
    SFX_SHORT   = 2'd1,
    SFX_BAD_SIG = 2'd2,
    SFX_BAD_CRC = 2'd3
  } sfx_status_e;

  typedef enum logic [1:0] {
    PK_NONE   = 2'd0,
    PK_TEXT   = 2'd1,
    PK_LEN8   = 2'd2,
    PK_MASK16 = 2'd3
  } prefix_kind_e;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [4:0] PreLenText = 5'd11;
  localparam logic [4:0] PreLen8    = 5'd8;
  localparam logic [4:0] PreLen16   = 5'd16;

  localparam logic [23:0] FwMax = 24'hFF_FFFF;

  typedef struct packed {
    sfx_status_e  status;
    logic [7:0]   sfx_len;
    logic [15:0]  dfu_version;
    logic [15:0]  vendor_id;
    logic [15:0]  product_id;
    logic [15:0]  device_release;
    prefix_kind_e kind;
    logic [4:0]   pre_len;
    logic [23:0]  fw_len;
    logic         pre_err;
    logic [25:0]  load_addr;
    logic [14:0]  kib;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_fold(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/dfusp_eval.sv
module dfusp_eval #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic [LENGTH_BITS-1:0] count_i,
  input  logic                   ovf_i,
  input  logic [31:0]            crc_i,
  input  logic [7:0][7:0]        head_i,
  input  logic [15:0][7:0]       win_i,
  output dfusp_pkg::result_t     result_o
);
  import dfusp_pkg::*;

  logic [31:0]  n32;
  logic [31:0]  crc_given;
  logic         sig_ok;
  sfx_status_e  status;
  logic [7:0]   sfx;
  logic [31:0]  given;
  logic [31:0]  expect_len;
  prefix_kind_e kind;
  logic [4:0]   pre;
  logic         err;
  logic [25:0]  addr;
  logic [14:0]  kib;
  logic [8:0]   used;
  logic [31:0]  used32;
  logic [31:0]  diff;
  logic [23:0]  fw;
  logic         err_fin;

  assign n32       = 32'(count_i);
  assign crc_given = {win_i[15], win_i[14], win_i[13], win_i[12]};
  assign sig_ok    = (win_i[10] == 8'h44) && (win_i[9] == 8'h46) && (win_i[8] == 8'h55);

  always_comb begin
    priority if (n32 < 32'd16) begin
      status = SFX_SHORT;
    end else if (!sig_ok) begin
      status = SFX_BAD_SIG;
    end else if (crc_given != crc_i) begin
      status = SFX_BAD_CRC;
    end else begin
      status = SFX_VALID;
    end
  end

  assign sfx        = (status == SFX_VALID) ? win_i[11] : 8'd0;
  assign given      = {head_i[7], head_i[6], head_i[5], head_i[4]};
  assign expect_len = n32 - 32'd8 - {24'b0, sfx};

  always_comb begin
    kind = PK_NONE;
    pre  = 5'd0;
    err  = ovf_i;
    addr = 26'd0;
    kib  = 15'd0;
    if (n32 < 32'd8) begin
      err = 1'b1;
    end else begin
      if (head_i[0] == 8'h44 && head_i[1] == 8'h66 && head_i[2] == 8'h75 &&
          head_i[3] == 8'h53 && head_i[4] == 8'h65) begin
        kind = PK_TEXT;
        pre  = PreLenText;
      end
      if (head_i[0] == 8'h01 && head_i[1] == 8'h00) begin
        if (given != expect_len) begin
          err = 1'b1;
        end else begin
          kind = PK_LEN8;
          pre  = PreLen8;
          addr = {head_i[3], head_i[2], 10'b0};
        end
      end else if ((head_i[0] & 8'h3F) == 8'h1A && (head_i[1] & 8'h3F) == 8'h3F) begin
        kind = PK_MASK16;
        pre  = PreLen16;
        kib  = {head_i[3], 7'b0} | {8'b0, head_i[2][7:1]};
      end
    end
  end

  // prefix plus suffix beyond the file also covers the overlap check
  assign used   = {4'b0, pre} + {1'b0, sfx};
  assign used32 = 32'(used);
  assign diff   = n32 - used32;

  always_comb begin
    err_fin = err;
    if (used32 > n32) begin
      fw      = 24'd0;
      err_fin = 1'b1;
    end else if (diff > 32'(FwMax)) begin
      fw = FwMax;
    end else begin
      fw = diff[23:0];
    end
  end

  always_comb begin
    result_o                = '0;
    result_o.status         = status;
    result_o.kind           = kind;
    result_o.pre_len        = pre;
    result_o.fw_len         = fw;
    result_o.pre_err        = err_fin;
    result_o.load_addr      = addr;
    result_o.kib            = kib;
    if (status == SFX_VALID) begin
      result_o.sfx_len        = win_i[11];
      result_o.dfu_version    = {win_i[7], win_i[6]};
      result_o.vendor_id      = {win_i[5], win_i[4]};
      result_o.product_id     = {win_i[3], win_i[2]};
      result_o.device_release = {win_i[1], win_i[0]};
    end
  end

endmodule

// File: src/dfu_suffix_prefix_checker.sv
// Firmware image suffix and prefix checker. Streams an image file in one byte per transfer
// (last_byte_i marks the final byte), counting bytes, keeping the first 8 and last 16
// bytes and running a reflected CRC-32 over all but the final four. A byte is taken
// every cycle unless a result waits unaccepted at the output with a second one held behind
// it; only the final byte of a file yields a result transfer, carrying the "UFD" suffix
// check and the prefix probe. The byte count is LENGTH_BITS wide and saturates, flagging
// prefix_error_o. Between the final byte and its result sit a snapshot register and an
// output register, so the next file streams in while a result waits to be taken.
module dfu_suffix_prefix_checker #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  suffix_status_o,
  output logic [7:0]  suffix_length_o,
  output logic [15:0] dfu_version_o,
  output logic [15:0] vendor_id_o,
  output logic [15:0] product_id_o,
  output logic [15:0] device_release_o,
  output logic [1:0]  prefix_kind_o,
  output logic [4:0]  prefix_length_o,
  output logic [23:0] firmware_length_o,
  output logic        prefix_error_o,
  output logic [25:0] load_address_o,
  output logic [14:0] masked_payload_kib_o
);
  import dfusp_pkg::*;

  logic [LENGTH_BITS-1:0] count_q, count_d, count_upd;
  logic [31:0]            crc_q, crc_d, crc_upd;
  logic [7:0][7:0]        head_q, head_d, head_upd;
  logic [15:0][7:0]       win_q, win_d, win_upd;
  logic                   ovf_q, ovf_d, ovf_upd;
  logic                   cnt_max;
  logic                   in_fire;

  logic [LENGTH_BITS-1:0] snap_count_q;
  logic [31:0]            snap_crc_q;
  logic [7:0][7:0]        snap_head_q;
  logic [15:0][7:0]       snap_win_q;
  logic                   snap_ovf_q;
  logic                   snap_valid_q, snap_valid_d;
  logic                   snap_adv;

  result_t                eval_res;
  result_t                out_res_q;
  logic                   out_valid_q;

  assign snap_adv   = !out_valid_q || out_ready_i;
  assign in_ready_o = !snap_valid_q || snap_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // per-byte state update
  assign cnt_max   = (count_q == {LENGTH_BITS{1'b1}});
  assign count_upd = cnt_max ? count_q : count_q + 1'b1;
  assign ovf_upd   = ovf_q | cnt_max;
  assign crc_upd   = (count_q >= LENGTH_BITS'(4)) ? crc_fold(crc_q, win_q[12]) : crc_q;
  assign win_upd   = {data_byte_i, win_q[15:1]};

  always_comb begin
    head_upd = head_q;
    if (count_q < LENGTH_BITS'(8)) begin
      head_upd[count_q[2:0]] = data_byte_i;
    end
  end

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    head_d  = head_q;
    win_d   = win_q;
    ovf_d   = ovf_q;
    if (in_fire) begin
      if (last_byte_i) begin
        count_d = '0;
        crc_d   = CrcInit;
        head_d  = '0;
        win_d   = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = count_upd;
        crc_d   = crc_upd;
        head_d  = head_upd;
        win_d   = win_upd;
        ovf_d   = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= CrcInit;
      head_q  <= '0;
      win_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      head_q  <= head_d;
      win_q   <= win_d;
      ovf_q   <= ovf_d;
    end
  end

  // snapshot of the file state on its final byte
  always_comb begin
    snap_valid_d = snap_valid_q;
    if (in_fire && last_byte_i) begin
      snap_valid_d = 1'b1;
    end else if (snap_adv) begin
      snap_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte_i) begin
      snap_count_q <= count_upd;
      snap_crc_q   <= crc_upd;
      snap_head_q  <= head_upd;
      snap_win_q   <= win_upd;
      snap_ovf_q   <= ovf_upd;
    end
  end

  dfusp_eval #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_eval (
    .count_i (snap_count_q),
    .ovf_i   (snap_ovf_q),
    .crc_i   (snap_crc_q),
    .head_i  (snap_head_q),
    .win_i   (snap_win_q),
    .result_o(eval_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_adv) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv && snap_valid_q) begin
      out_res_q <= eval_res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign suffix_status_o      = out_res_q.status;
  assign suffix_length_o      = out_res_q.sfx_len;
  assign dfu_version_o        = out_res_q.dfu_version;
  assign vendor_id_o          = out_res_q.vendor_id;
  assign product_id_o         = out_res_q.product_id;
  assign device_release_o     = out_res_q.device_release;
  assign prefix_kind_o        = out_res_q.kind;
  assign prefix_length_o      = out_res_q.pre_len;
  assign firmware_length_o    = out_res_q.fw_len;
  assign prefix_error_o       = out_res_q.pre_err;
  assign load_address_o       = out_res_q.load_addr;
  assign masked_payload_kib_o = out_res_q.kib;

endmodule
